>>> rtl/core/buddy_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared property shorthands, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/bbalc_pkg.sv
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Widths, status codes, defaults and the queued job word.
// ----------------------------------------------------------------------------
package bbalc_pkg;

   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 18;
   localparam int LEVEL_W     = 5;   // holds levels up to 31
   localparam int OUT_LEVEL_W = 4;
   localparam int STATUS_W    = 2;

   localparam int DEF_NUM_PAGES  = 64;
   localparam int DEF_PAGE_LEVEL = 12;
   localparam int DEF_MIN_LEVEL  = 4;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [STATUS_W-1:0] ST_GRANTED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic               too_large;
      logic [LEVEL_W-1:0] target;
   } job_type;

endpackage

>>> rtl/core/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocate-only buddy allocator over NUM_PAGES pages of 2^PAGE_LEVEL bytes.
// req_ channel: one word per request, req_request_size in bytes. The word is
// taken at an edge with req_valid high and req_stall low.
// rsp_ channel: one word per request, in request order: rsp_status,
// rsp_block_address, rsp_block_level. Taken when rsp_valid and !rsp_stall.
// The job is registered in the queue, then the back end fires from the queue
// head into the result register that drives rsp_valid.
// Throughput: one request per cycle while rsp_stall does not hold the result;
// the back end handles one job a cycle, as the free-level search and split
// update are combinational.
// A two-word job queue separates the classifier from the back end, so a
// stalled rsp_ side fills the queue and then raises req_stall.
// Reset (synchronous): all levels empty, no pages used, queue and result
// register empty. Oversize and exhausted requests leave state untouched.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
   parameter int NUM_PAGES  = bbalc_pkg::DEF_NUM_PAGES,
   parameter int PAGE_LEVEL = bbalc_pkg::DEF_PAGE_LEVEL,
   parameter int MIN_LEVEL  = bbalc_pkg::DEF_MIN_LEVEL
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bbalc_pkg::SIZE_W-1:0]       req_request_size,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bbalc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bbalc_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic [bbalc_pkg::OUT_LEVEL_W-1:0]  rsp_block_level
);

   // classified job from the front end into the queue
   logic               push;
   logic               queue_full;
   bbalc_pkg::job_type push_job;

   // queue head toward the back end
   logic               head_valid;
   logic               head_pop;
   bbalc_pkg::job_type head_job;

   // front: rounds the size up to a level and flags oversize requests
   bbalc_front #(
      .PAGE_LEVEL (PAGE_LEVEL),
      .MIN_LEVEL  (MIN_LEVEL)
   ) u_front (
      .req_valid        (req_valid),
      .req_request_size (req_request_size),
      .req_stall        (req_stall),
      .queue_full       (queue_full),
      .push             (push),
      .job              (push_job)
   );

   bbalc_queue #(
      .DEPTH (bbalc_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // back: owns the free lists and page count, drives the result register
   bbalc_back #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_LEVEL (PAGE_LEVEL),
      .MIN_LEVEL  (MIN_LEVEL)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (head_valid),
      .job               (head_job),
      .job_pop           (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_block_level   (rsp_block_level)
   );

endmodule

>>> rtl/core/bbalc_front.sv
// ----------------------------------------------------------------------------
// Buddy allocator front end
// Takes request words and classifies them: oversize flag and target level.
// ----------------------------------------------------------------------------
module bbalc_front #(
   parameter int PAGE_LEVEL = bbalc_pkg::DEF_PAGE_LEVEL,
   parameter int MIN_LEVEL  = bbalc_pkg::DEF_MIN_LEVEL
) (
   input  logic                          req_valid,
   input  logic [bbalc_pkg::SIZE_W-1:0]  req_request_size,
   output logic                          req_stall,
   input  logic                          queue_full,
   output logic                          push,
   output bbalc_pkg::job_type            job
);

   localparam int WIDE_W = bbalc_pkg::SIZE_W + 1;
   localparam logic [WIDE_W-1:0] PAGE_BYTES = WIDE_W'(1) << PAGE_LEVEL;

   logic [WIDE_W-1:0]             size_wide;
   logic [bbalc_pkg::LEVEL_W-1:0] target;

   assign size_wide = {1'b0, req_request_size};

   // smallest level whose block covers the size, page level otherwise
   always_comb begin
      target = bbalc_pkg::LEVEL_W'(PAGE_LEVEL);
      for (int t = PAGE_LEVEL - 1; t >= MIN_LEVEL; t--) begin
         if (size_wide <= (WIDE_W'(1) << t)) begin
            target = bbalc_pkg::LEVEL_W'(t);
         end
      end
   end

   assign job.too_large = (size_wide > PAGE_BYTES);
   assign job.target    = target;
   assign req_stall     = queue_full;
   assign push          = req_valid && !queue_full;

endmodule

>>> rtl/core/bbalc_queue.sv
// ----------------------------------------------------------------------------
// Buddy allocator job queue
// Short FIFO of classified jobs between front and back end (depth >= 2).
// ----------------------------------------------------------------------------
module bbalc_queue #(
   parameter int DEPTH = bbalc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bbalc_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bbalc_pkg::job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bbalc_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/bbalc_back.sv
// ----------------------------------------------------------------------------
// Buddy allocator back end
// Free-level search, page take, split-down and the result register.
// ----------------------------------------------------------------------------
module bbalc_back #(
   parameter int NUM_PAGES  = bbalc_pkg::DEF_NUM_PAGES,
   parameter int PAGE_LEVEL = bbalc_pkg::DEF_PAGE_LEVEL,
   parameter int MIN_LEVEL  = bbalc_pkg::DEF_MIN_LEVEL
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  bbalc_pkg::job_type                 job,
   output logic                               job_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bbalc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bbalc_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic [bbalc_pkg::OUT_LEVEL_W-1:0]  rsp_block_level
);

   localparam int PU_W    = $clog2(NUM_PAGES + 1);
   localparam int ADDR_W  = bbalc_pkg::ADDR_W;
   localparam int LEVEL_W = bbalc_pkg::LEVEL_W;

   logic                  has_free_ff [PAGE_LEVEL];
   logic                  has_free_in [PAGE_LEVEL];
   logic [ADDR_W-1:0]     free_addr_ff [PAGE_LEVEL];
   logic [ADDR_W-1:0]     free_addr_in [PAGE_LEVEL];
   logic [PU_W-1:0]       pages_used_ff, pages_used_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bbalc_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]                   rsp_addr_ff, rsp_addr_in;
   logic [bbalc_pkg::OUT_LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic                        fire;
   logic                        found;
   logic [LEVEL_W-1:0]          found_lvl;
   logic [ADDR_W-1:0]           found_addr;
   logic [PU_W+PAGE_LEVEL-1:0]  page_wide;
   logic [ADDR_W-1:0]           page_base;
   logic                        exhausted;
   logic                        grant;
   logic [ADDR_W-1:0]           base;
   logic [LEVEL_W-1:0]          from_lvl;

   assign fire    = job_valid && (!rsp_valid_ff || !rsp_stall);
   assign job_pop = fire;

   // lowest level at or above target holding a free block
   always_comb begin
      found      = 1'b0;
      found_lvl  = LEVEL_W'(PAGE_LEVEL);
      found_addr = '0;
      for (int k = PAGE_LEVEL - 1; k >= MIN_LEVEL; k--) begin
         if (has_free_ff[k] && (LEVEL_W'(k) >= job.target)) begin
            found      = 1'b1;
            found_lvl  = LEVEL_W'(k);
            found_addr = free_addr_ff[k];
         end
      end
   end

   assign page_wide = {pages_used_ff, {PAGE_LEVEL{1'b0}}};
   assign page_base = ADDR_W'(page_wide);
   assign exhausted = !found && (pages_used_ff >= PU_W'(NUM_PAGES));
   assign grant     = !job.too_large && !exhausted;
   assign base      = found ? found_addr : page_base;
   assign from_lvl  = found ? found_lvl : LEVEL_W'(PAGE_LEVEL);

   always_comb begin
      has_free_in   = has_free_ff;
      free_addr_in  = free_addr_ff;
      pages_used_in = pages_used_ff;
      if (fire && grant) begin
         if (!found) begin
            pages_used_in = pages_used_ff + PU_W'(1);
         end
         for (int k = MIN_LEVEL; k < PAGE_LEVEL; k++) begin
            if (found && (LEVEL_W'(k) == found_lvl)) begin
               has_free_in[k] = 1'b0;
            end
            // right half of each split becomes the level's free block
            if ((LEVEL_W'(k) >= job.target) && (LEVEL_W'(k) < from_lvl)) begin
               has_free_in[k]  = 1'b1;
               free_addr_in[k] = base + (ADDR_W'(1) << k);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_level_in  = rsp_level_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (job.too_large) begin
            rsp_status_in = bbalc_pkg::ST_TOO_LARGE;
            rsp_addr_in   = '0;
            rsp_level_in  = bbalc_pkg::OUT_LEVEL_W'(MIN_LEVEL);
         end else if (exhausted) begin
            rsp_status_in = bbalc_pkg::ST_EXHAUSTED;
            rsp_addr_in   = '0;
            rsp_level_in  = bbalc_pkg::OUT_LEVEL_W'(MIN_LEVEL);
         end else begin
            rsp_status_in = bbalc_pkg::ST_GRANTED;
            rsp_addr_in   = base;
            rsp_level_in  = bbalc_pkg::OUT_LEVEL_W'(job.target);
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_free_ff   <= '{default: 1'b0};
         pages_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         has_free_ff   <= has_free_in;
         pages_used_ff <= pages_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_addr_ff  <= free_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_block_level   = rsp_level_ff;

endmodule

>>> rtl/core/bbalc_checker.sv
// ----------------------------------------------------------------------------
// Buddy allocator port checker
// Port-level properties on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_defines.svh"

module bbalc_checker #(
   parameter int MIN_LEVEL = bbalc_pkg::DEF_MIN_LEVEL
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [bbalc_pkg::STATUS_W-1:0]     rsp_status,
   input logic [bbalc_pkg::ADDR_W-1:0]       rsp_block_address,
   input logic [bbalc_pkg::OUT_LEVEL_W-1:0]  rsp_block_level
);

   localparam int ADDR_W = bbalc_pkg::ADDR_W;

   logic [ADDR_W-1:0] align_mask;
   logic              rsp_error;
   logic              rsp_grant;
   logic              error_ok;
   logic              rsp_hold;

   assign align_mask = (ADDR_W'(1) << rsp_block_level) - ADDR_W'(1);
   assign rsp_error  = rsp_valid && (rsp_status != bbalc_pkg::ST_GRANTED);
   assign rsp_grant  = rsp_valid && (rsp_status == bbalc_pkg::ST_GRANTED);
   assign error_ok   = (rsp_block_address == '0) &&
                       (rsp_block_level == bbalc_pkg::OUT_LEVEL_W'(MIN_LEVEL));
   assign rsp_hold   = rsp_valid && rsp_stall;

   // errors carry a zero address and the minimum level
   `BBA_ASSERT_NOW(a_error_fields, rsp_error, error_ok)

   // a granted block is aligned to its own size
   `BBA_ASSERT_NOW(a_grant_aligned, rsp_grant, (rsp_block_address & align_mask) == '0)

   `BBA_ASSERT_NEXT(a_rsp_held, rsp_hold, rsp_valid)

   `BBA_ASSERT_NEXT(a_rsp_stable, rsp_hold, $stable({rsp_status, rsp_block_address, rsp_block_level}))

endmodule

bind buddy_block_allocator bbalc_checker #(
   .MIN_LEVEL (MIN_LEVEL)
) u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_block_address (rsp_block_address),
   .rsp_block_level   (rsp_block_level)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocation requests: directed corner sizes first, then random
// bursts, then full-page requests until the pool runs dry. A shadow
// allocator predicts each response word, and the responses are checked in
// order against it. The response side stalls at random and holds off once
// for a long stretch, so the job queue fills and the request side stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SIZE_W      = bbalc_pkg::SIZE_W;
   localparam int ADDR_W      = bbalc_pkg::ADDR_W;
   localparam int STATUS_W    = bbalc_pkg::STATUS_W;
   localparam int OUT_LEVEL_W = bbalc_pkg::OUT_LEVEL_W;

   localparam int NUM_PAGES  = bbalc_pkg::DEF_NUM_PAGES;
   localparam int PAGE_LEVEL = bbalc_pkg::DEF_PAGE_LEVEL;
   localparam int MIN_LEVEL  = bbalc_pkg::DEF_MIN_LEVEL;
   localparam int PAGE_BYTES = 1 << PAGE_LEVEL;

   // Sizes around rounding boundaries, the page limit and the top bits.
   localparam logic [SIZE_W-1:0] CORNER_SIZES [24] = '{
      16'd0, 16'd1, 16'd15, 16'd16, 16'd17, 16'd31, 16'd32, 16'd33,
      16'd64, 16'd100, 16'd255, 16'd256, 16'd1024, 16'd2047, 16'd2048,
      16'd2049, 16'd4095, 16'd4096, 16'd4097, 16'd8192, 16'h5555,
      16'hAAAA, 16'h8000, 16'hFFFF
   };

   // One response word as the block should return it.
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ADDR_W-1:0]      address;
      logic [OUT_LEVEL_W-1:0] level;
   } grant_type;

   // --------------------------------------------------------------------
   // Shadow allocator plus in-order queue of predicted response words.
   // --------------------------------------------------------------------
   class grant_ledger;
      bit                has_free [16];
      logic [ADDR_W-1:0] free_addr [16];
      int                pages_used;
      grant_type         expected_grants [$];
      int unsigned       mismatch_count;
      int unsigned       granted_count;
      int unsigned       too_large_count;
      int unsigned       exhausted_count;

      function new();
         foreach (has_free[k]) begin
            has_free[k]  = 1'b0;
            free_addr[k] = '0;
         end
         pages_used      = 0;
         mismatch_count  = 0;
         granted_count   = 0;
         too_large_count = 0;
         exhausted_count = 0;
      endfunction

      // Rounds the size up, takes the smallest free level at or above the
      // target (or a fresh page) and leaves right halves on the way down.
      function grant_type predict_grant(logic [SIZE_W-1:0] size);
         grant_type         g;
         int                target;
         int                lvl;
         logic [ADDR_W-1:0] base;
         g.status  = bbalc_pkg::ST_GRANTED;
         g.address = '0;
         g.level   = OUT_LEVEL_W'(MIN_LEVEL);
         if (size > PAGE_BYTES) begin
            g.status = bbalc_pkg::ST_TOO_LARGE;
            return g;
         end
         target = MIN_LEVEL;
         while (target < PAGE_LEVEL && (1 << target) < size) target++;
         lvl = target;
         while (lvl < PAGE_LEVEL && !has_free[lvl]) lvl++;
         if (lvl < PAGE_LEVEL) begin
            base          = free_addr[lvl];
            has_free[lvl] = 1'b0;
         end else if (pages_used >= NUM_PAGES) begin
            g.status = bbalc_pkg::ST_EXHAUSTED;
            return g;
         end else begin
            base = ADDR_W'(pages_used << PAGE_LEVEL);
            pages_used++;
         end
         for (int k = target; k < lvl; k++) begin
            free_addr[k] = ADDR_W'(base + (1 << k));
            has_free[k]  = 1'b1;
         end
         g.address = base;
         g.level   = OUT_LEVEL_W'(target);
         return g;
      endfunction

      function void note_request(logic [SIZE_W-1:0] size);
         grant_type g;
         g = predict_grant(size);
         case (g.status)
            bbalc_pkg::ST_GRANTED:   granted_count++;
            bbalc_pkg::ST_TOO_LARGE: too_large_count++;
            default:                 exhausted_count++;
         endcase
         expected_grants.push_back(g);
      endfunction

      function int pending();
         return expected_grants.size();
      endfunction

      task flag_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_grant(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] addr,
                       logic [OUT_LEVEL_W-1:0] lvl);
         grant_type e;
         if (expected_grants.size() == 0) begin
            flag_mismatch($sformatf("response word with none pending (status %0d)", st));
            return;
         end
         e = expected_grants.pop_front();
         if (st !== e.status)
            flag_mismatch($sformatf("status %0d, want %0d", st, e.status));
         if (addr !== e.address)
            flag_mismatch($sformatf("address 0x%05h, want 0x%05h", addr, e.address));
         if (lvl !== e.level)
            flag_mismatch($sformatf("level %0d, want %0d", lvl, e.level));
      endtask
   endclass

   // --------------------------------------------------------------------
   // Clock, DUT and its ports
   // --------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [SIZE_W-1:0]      req_request_size;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ADDR_W-1:0]      rsp_block_address;
   logic [OUT_LEVEL_W-1:0] rsp_block_level;

   grant_ledger ledger = new();
   bit          rsp_holding = 1'b0;   // set while the long hold-off runs

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   buddy_block_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_request_size  (req_request_size),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_block_level   (rsp_block_level)
   );

   // --------------------------------------------------------------------
   // Request side. offer() holds a word on the port until the edge that
   // takes it; the caller then either offers the next word (valid stays
   // high, one assignment) or pauses (valid drops).
   // --------------------------------------------------------------------
   task automatic offer(input logic [SIZE_W-1:0] size);
      req_valid        <= 1'b1;
      req_request_size <= size;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Both monitors sample pre-edge values; the response is checked before the
   // request is noted so an early response cannot match its own request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_grant(rsp_status, rsp_block_address, rsp_block_level);
      if (!reset && req_valid && !req_stall)
         ledger.note_request(req_request_size);
   end

   // --------------------------------------------------------------------
   // Response side: windows rotate through no stall, light stall and heavy
   // stall. Once, a long hold-off lets the queue fill so the request side
   // backs up.
   // --------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned cyc;
      cyc = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         rsp_holding = (cyc >= 200 && cyc < 280);
         if (rsp_holding)
            rsp_stall <= 1'b1;
         else begin
            case ((cyc / 64) % 3)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   // --------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------
   initial begin : req_side
      int                burst_left;
      logic [SIZE_W-1:0] size;
      req_valid        <= 1'b0;
      req_request_size <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero and tiny sizes, rounding edges, page edge, oversize
      foreach (CORNER_SIZES[i]) offer(CORNER_SIZES[i]);

      // random bursts; gaps vanish during the hold-off to keep pressure on
      burst_left = 0;
      for (int n = 0; n < 400; n++) begin
         if (burst_left == 0) begin
            pause_requests(rsp_holding ? 0 : $urandom_range(0, 8));
            burst_left = $urandom_range(1, 12);
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:  size = SIZE_W'($urandom_range(0, 64));
            6, 7, 8, 9, 10:    size = SIZE_W'($urandom_range(65, 2048));
            11, 12, 13, 14:    size = SIZE_W'($urandom_range(2049, PAGE_BYTES));
            15, 16:            size = SIZE_W'(1 << $urandom_range(0, PAGE_LEVEL));
            17, 18:            size = SIZE_W'($urandom_range(PAGE_BYTES + 1, 65535));
            default:           size = SIZE_W'($urandom_range(0, 65535));
         endcase
         offer(size);
         burst_left--;
      end

      // pool exhaustion: whole pages until several requests are refused
      while (ledger.exhausted_count < 6) offer(SIZE_W'(PAGE_BYTES));

      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d grants, %0d oversize and %0d out-of-pages refusals;",
               ledger.granted_count, ledger.too_large_count, ledger.exhausted_count);
      $display("all %0d pages handed out, response side stalled at random and held off",
               ledger.pages_used);
      if (ledger.mismatch_count == 0 && ledger.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin : watchdog
      #400000;
      $display("timeout with %0d response words outstanding", ledger.pending());
      $display("TB_ERROR");
      $finish;
   end

endmodule
